// File: rtl/core/wvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wvg_pkg;

    // value and interval formats
    localparam int VALUE_W       = 32;
    localparam int INTERVAL_W    = 16;
    localparam int INTERVAL_FRAC = 8;
    localparam int MODE_W        = 3;
    localparam int PROB_W        = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int LCG_W         = 48;
    localparam int LCG_HALF      = LCG_W / 2;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // mode codes
    localparam logic [MODE_W-1:0] MODE_CONST   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNIFORM = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RWALK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DWALK   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROB  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 3'd5;

    // generator constants
    localparam logic [34:0]       LCG_MUL   = 35'h5DEECE66D;
    localparam logic [LCG_W-1:0]  LCG_INC   = 48'hB;
    localparam logic [LCG_W-1:0]  LCG_SEED  = 48'h1234ABCD330E;
    localparam logic [PROB_W-1:0] PROB_ONE  = 17'h10000;
    localparam logic [PROB_W-1:0] PROB_HALF = 17'h08000;

    // operation chosen by the front for one request
    typedef enum logic [2:0] {
        OP_CONST   = 3'd0,
        OP_UNUSED  = 3'd1,
        OP_ERROR   = 3'd2,
        OP_UNIFORM = 3'd3,
        OP_LINEAR  = 3'd4,
        OP_RWALK   = 3'd5,
        OP_DWALK   = 3'd6
    } op_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] start_value;
        logic signed [VALUE_W-1:0] step_size;
        logic [PROB_W-1:0]         keep_probability;
        logic signed [VALUE_W-1:0] bound_lo;
        logic signed [VALUE_W-1:0] bound_hi;
    } cfg_t;

    typedef struct packed {
        op_t                   op;
        logic [INTERVAL_W-1:0] interval;
    } qent_t;

    typedef struct packed {
        logic  push;
        qent_t data;
    } qpush_t;

    typedef struct packed {
        logic  full;
        logic  empty;
        qent_t head;
    } qstat_t;

endpackage

`default_nettype wire

// File: rtl/core/wvg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wvg_front (
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [wvg_pkg::INTERVAL_W-1:0] s_interval,
    input  wire  wvg_pkg::cfg_t           cfg,
    input  wire  wvg_pkg::qstat_t         qstat,
    output wvg_pkg::qpush_t               qpush
);
    import wvg_pkg::*;

    op_t op_w;
    logic bounds_bad;

    assign bounds_bad = $signed(cfg.bound_lo) > $signed(cfg.bound_hi);

    always_comb begin
        case (cfg.mode)
            MODE_CONST:   op_w = OP_CONST;
            MODE_UNIFORM: op_w = bounds_bad ? OP_ERROR : OP_UNIFORM;
            MODE_LINEAR:  op_w = bounds_bad ? OP_ERROR : OP_LINEAR;
            MODE_RWALK:   op_w = bounds_bad ? OP_ERROR : OP_RWALK;
            MODE_DWALK:   op_w = bounds_bad ? OP_ERROR : OP_DWALK;
            default:      op_w = OP_UNUSED;
        endcase
    end

    assign s_ready             = !qstat.full;
    assign qpush.push          = s_valid && !qstat.full;
    assign qpush.data.op       = op_w;
    assign qpush.data.interval = s_interval;

endmodule

`default_nettype wire

// File: rtl/core/wvg_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wvg_queue (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire  wvg_pkg::qpush_t  qpush,
    input  wire                    pop,
    output wvg_pkg::qstat_t        qstat
);
    import wvg_pkg::*;

    qent_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign do_push = qpush.push && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= qpush.data;
        end
    end

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.head  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: rtl/core/wvg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wvg_back (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire  wvg_pkg::cfg_t                 cfg,
    input  wire                                 cfg_we,
    input  wire  wvg_pkg::qstat_t               qstat,
    output logic                                q_pop,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [wvg_pkg::VALUE_W-1:0]  m_value,
    output logic                                m_config_error
);
    import wvg_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_LCG_MUL = 8'b0000_0010,
        ST_LCG_ADD = 8'b0000_0100,
        ST_FLIP    = 8'b0000_1000,
        ST_MUL     = 8'b0001_0000,
        ST_SUM     = 8'b0010_0000,
        ST_SIMPLE  = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } state_t;

    localparam int WALK_W = VALUE_W + 10;

    function automatic logic signed [VALUE_W-1:0] neg_step(input logic signed [VALUE_W-1:0] s);
        logic signed [VALUE_W-1:0] vmin;
        vmin = {1'b1, {(VALUE_W-1){1'b0}}};
        if (s == vmin) begin
            neg_step = ~vmin;
        end else begin
            neg_step = -s;
        end
    endfunction

    state_t                     state_reg, state_next;
    op_t                        op_reg, op_next;
    logic [INTERVAL_W-1:0]      interval_reg, interval_next;
    logic [LCG_W-1:0]           lcg_reg, lcg_next;
    logic [LCG_W-1:0]           p0_reg, p0_next;
    logic [LCG_HALF-1:0]        p1_reg, p1_next;
    logic signed [VALUE_W-1:0]  step_sel_reg, step_sel_next;
    logic [2*VALUE_W-1:0]       prod_reg, prod_next;
    logic signed [VALUE_W-1:0]  cur_value_reg, cur_value_next;
    logic signed [VALUE_W-1:0]  cur_step_reg, cur_step_next;
    logic                       started_reg, started_next;
    logic signed [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic                       res_err_reg, res_err_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [VALUE_W-1:0]  m_value_reg, m_value_next;
    logic                       m_err_reg, m_err_next;

    // lcg partial products
    logic [LCG_W-1:0]           lcg_prod0;
    logic [LCG_HALF-1:0]        lcg_prod1;
    logic [LCG_W-1:0]           lcg_sum;

    // flip decision
    logic [PROB_W-1:0]          prob_c;
    logic                       flip_w;
    logic signed [VALUE_W-1:0]  s0_w;

    // shared multiplier
    logic [VALUE_W-1:0]         range_w, step_mag_w, mul_a, mul_b;
    logic [2*VALUE_W-1:0]       mul_p;

    // walk sum and clamp
    logic [WALK_W-3:0]          delta_mag_w;
    logic signed [WALK_W-1:0]   delta_w, base_ext, lower_ext, upper_ext, walk_sum;
    logic signed [VALUE_W-1:0]  base_w, walk_value, walk_step;
    logic                       walk_hit;

    // linear
    logic signed [VALUE_W:0]    lin_sum, lin_lower, lin_upper;
    logic signed [VALUE_W-1:0]  lin_value;

    logic signed [VALUE_W-1:0]  uni_value;

    assign lcg_prod0 = LCG_W'(lcg_reg[LCG_HALF-1:0]) * LCG_W'(LCG_MUL);
    assign lcg_prod1 = lcg_reg[LCG_W-1:LCG_HALF] * LCG_MUL[LCG_HALF-1:0];
    assign lcg_sum   = p0_reg + {p1_reg, {LCG_HALF{1'b0}}} + LCG_INC;

    assign prob_c = (cfg.keep_probability > PROB_ONE) ? PROB_ONE : cfg.keep_probability;
    assign flip_w = {1'b0, lcg_reg} > {prob_c, {VALUE_W{1'b0}}};
    assign s0_w   = (op_reg == OP_DWALK && started_reg) ? cur_step_reg : cfg.step_size;

    assign range_w    = cfg.bound_hi - cfg.bound_lo;
    assign step_mag_w = step_sel_reg[VALUE_W-1] ? (VALUE_W'(0) - step_sel_reg) : step_sel_reg;
    assign mul_a      = (op_reg == OP_UNIFORM) ? range_w : step_mag_w;
    assign mul_b      = (op_reg == OP_UNIFORM) ? lcg_reg[LCG_W-1:LCG_W-VALUE_W]
                                               : VALUE_W'(interval_reg);
    assign mul_p      = (2*VALUE_W)'(mul_a) * (2*VALUE_W)'(mul_b);

    // |step| * interval fits in 48 bits, scaled magnitude in 40
    assign delta_mag_w = prod_reg[WALK_W-3+INTERVAL_FRAC:INTERVAL_FRAC];
    assign delta_w     = step_sel_reg[VALUE_W-1] ? -$signed({2'b00, delta_mag_w})
                                                 : $signed({2'b00, delta_mag_w});
    assign base_w      = started_reg ? cur_value_reg : cfg.start_value;
    assign base_ext    = WALK_W'(base_w);
    assign lower_ext   = WALK_W'(cfg.bound_lo);
    assign upper_ext   = WALK_W'(cfg.bound_hi);
    assign walk_sum    = base_ext + delta_w;

    always_comb begin
        walk_value = walk_sum[VALUE_W-1:0];
        walk_hit   = 1'b0;
        if (walk_sum < lower_ext) begin
            walk_value = cfg.bound_lo;
            walk_hit   = 1'b1;
        end else if (walk_sum > upper_ext) begin
            walk_value = cfg.bound_hi;
            walk_hit   = 1'b1;
        end
    end

    assign walk_step = walk_hit ? neg_step(step_sel_reg) : step_sel_reg;

    assign lin_sum   = started_reg ? ((VALUE_W+1)'(cur_value_reg) + (VALUE_W+1)'(cfg.step_size))
                                   : (VALUE_W+1)'(cfg.start_value);
    assign lin_lower = (VALUE_W+1)'(cfg.bound_lo);
    assign lin_upper = (VALUE_W+1)'(cfg.bound_hi);

    always_comb begin
        if (lin_sum < lin_lower) begin
            lin_value = cfg.bound_hi;
        end else if (lin_sum > lin_upper) begin
            lin_value = cfg.bound_lo;
        end else begin
            lin_value = lin_sum[VALUE_W-1:0];
        end
    end

    assign uni_value = cfg.bound_lo + prod_reg[2*VALUE_W-1:VALUE_W];

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        interval_next  = interval_reg;
        lcg_next       = lcg_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        step_sel_next  = step_sel_reg;
        prod_next      = prod_reg;
        cur_value_next = cur_value_reg;
        cur_step_next  = cur_step_reg;
        started_next   = started_reg;
        res_value_next = res_value_reg;
        res_err_next   = res_err_reg;
        m_valid_next   = m_valid_reg;
        m_value_next   = m_value_reg;
        m_err_next     = m_err_reg;
        q_pop          = 1'b0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (!qstat.empty) begin
                    q_pop         = 1'b1;
                    op_next       = qstat.head.op;
                    interval_next = qstat.head.interval;
                    case (qstat.head.op)
                        OP_UNIFORM, OP_RWALK, OP_DWALK: state_next = ST_LCG_MUL;
                        default:                        state_next = ST_SIMPLE;
                    endcase
                end
            end
            ST_LCG_MUL: begin
                p0_next    = lcg_prod0;
                p1_next    = lcg_prod1;
                state_next = ST_LCG_ADD;
            end
            ST_LCG_ADD: begin
                lcg_next   = lcg_sum;
                state_next = (op_reg == OP_UNIFORM) ? ST_MUL : ST_FLIP;
            end
            ST_FLIP: begin
                step_sel_next = flip_w ? neg_step(s0_w) : s0_w;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                res_err_next = 1'b0;
                if (op_reg == OP_UNIFORM) begin
                    res_value_next = uni_value;
                end else begin
                    res_value_next = walk_value;
                    cur_value_next = walk_value;
                    started_next   = 1'b1;
                    if (op_reg == OP_DWALK) begin
                        cur_step_next = walk_step;
                    end
                end
                state_next = ST_OUT;
            end
            ST_SIMPLE: begin
                res_err_next   = 1'b0;
                res_value_next = '0;
                case (op_reg)
                    OP_CONST: res_value_next = cfg.start_value;
                    OP_ERROR: res_err_next = 1'b1;
                    OP_LINEAR: begin
                        res_value_next = lin_value;
                        cur_value_next = lin_value;
                        started_next   = 1'b1;
                    end
                    default: res_value_next = '0;
                endcase
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg_we) begin
            started_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lcg_reg       <= LCG_SEED;
            cur_value_reg <= '0;
            cur_step_reg  <= '0;
            started_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lcg_reg       <= lcg_next;
            cur_value_reg <= cur_value_next;
            cur_step_reg  <= cur_step_next;
            started_reg   <= started_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        interval_reg  <= interval_next;
        p0_reg        <= p0_next;
        p1_reg        <= p1_next;
        step_sel_reg  <= step_sel_next;
        prod_reg      <= prod_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        m_value_reg   <= m_value_next;
        m_err_reg     <= m_err_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_value        = m_value_reg;
    assign m_config_error = m_err_reg;

endmodule

`default_nettype wire

// File: rtl/core/workload_value_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+---------------------------------
// s_        | in        | s_valid / s_ready  | s_interval (u16, Q8.8)
// m_        | out       | m_valid / m_ready  | m_value (s32, Q16.16), m_config_error
// cfg_      | in        | cfg_we             | cfg_index, cfg_data (write only)
//
// a request goes from the queue to the output register via the simple state
// in constant, linear, error and unused cases; uniform and walk modes use the
// back end's sequencer (two-step 48-bit lcg multiply, walk step flip, 32x32
// shared multiplier, then the sum and clamp), taking one request at a time
// a two-entry request queue lets the front keep accepting while the back is busy
// and the output register holds a result that has not been taken
// reset is synchronous and active low; no clearing pass is needed

module workload_value_generator (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [wvg_pkg::INTERVAL_W-1:0]     s_interval,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic signed [wvg_pkg::VALUE_W-1:0] m_value,
    output logic                               m_config_error,
    input  wire                                cfg_we,
    input  wire  [wvg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [wvg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wvg_pkg::*;

    // configuration registers; the user writes them only while idle (not enforced)
    cfg_t   cfg_reg;
    qpush_t qpush;
    qstat_t qstat;
    logic   q_pop;
    logic   cfg_clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode             <= MODE_CONST;
            cfg_reg.start_value      <= '0;
            cfg_reg.step_size        <= '0;
            cfg_reg.keep_probability <= PROB_HALF;
            cfg_reg.bound_lo         <= '0;
            cfg_reg.bound_hi         <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE:  cfg_reg.mode             <= cfg_data[MODE_W-1:0];
                REG_START: cfg_reg.start_value      <= cfg_data[VALUE_W-1:0];
                REG_STEP:  cfg_reg.step_size        <= cfg_data[VALUE_W-1:0];
                REG_PROB:  cfg_reg.keep_probability <= cfg_data[PROB_W-1:0];
                REG_LOWER: cfg_reg.bound_lo         <= cfg_data[VALUE_W-1:0];
                REG_UPPER: cfg_reg.bound_hi         <= cfg_data[VALUE_W-1:0];
                // writes beyond the list are dropped and leave the walk running
                default: cfg_reg.mode <= cfg_reg.mode;
            endcase
        end
    end

    // only a write to a real register restarts linear and walk modes
    assign cfg_clear = cfg_we && (cfg_index <= REG_UPPER);

    // front: accepts a request and classifies it by mode and bound check
    wvg_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_interval (s_interval),
        .cfg        (cfg_reg),
        .qstat      (qstat),
        .qpush      (qpush)
    );

    // short request queue between front and back
    wvg_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .qpush   (qpush),
        .pop     (q_pop),
        .qstat   (qstat)
    );

    // back: lcg, multiplier, walk and wrap arithmetic, output register
    wvg_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cfg_we         (cfg_clear),
        .qstat          (qstat),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_config_error (m_config_error)
    );

`ifndef NO_ASSERTIONS
    // an error result always carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_config_error) |-> (m_value == '0))
        else $error("config error reported with non-zero value");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !qpush.push)
        else $error("request pushed into full queue");

    // the back only pops when a request is waiting
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !qstat.empty)
        else $error("request popped from empty queue");

    // a push into an empty queue leaves a request at the head next cycle
    a_push_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (qpush.push && qstat.empty) |=> !qstat.empty)
        else $error("pushed request lost");
`endif

endmodule

`default_nettype wire

// File: tb/tb_workload_value_generator.sv
`timescale 1ns / 1ps

module tb_workload_value_generator;
    import wvg_pkg::*;

    // run limits and pacing
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 250;
    localparam int RANDOM_ITEMS = 400;
    localparam int Q_ONE        = 65536;

    // codes the package does not name
    localparam logic [MODE_W-1:0]    MODE_UNUSED_FIRST = MODE_DWALK + 3'd1;
    localparam logic [MODE_W-1:0]    MODE_UNUSED_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE         = REG_UPPER + 3'd1;

    // generator arithmetic
    localparam bit [63:0]       MULT_48   = 64'h5_DEEC_E66D;
    localparam bit [63:0]       INC_48    = 64'hB;
    localparam bit [47:0]       SEED_48   = 48'h1234_ABCD_330E;
    localparam longint unsigned STEP_CAP  = 64'h4000_0000_0000_0000;
    localparam longint          VALUE_MAX = 64'sd2147483647;
    localparam longint          VALUE_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      config_error;
    } gen_result_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    wire                          s_ready;
    logic [INTERVAL_W-1:0]        s_interval = '0;
    wire                          m_valid;
    logic                         m_ready = 1'b0;
    wire signed [VALUE_W-1:0]     m_value;
    wire                          m_config_error;
    logic                         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    // stimulus and expectation stores
    bit [INTERVAL_W-1:0] pending_ticks[$];
    gen_result_t         expected_results[$];

    // predictor copy of the registers
    bit [MODE_W-1:0] gen_mode;
    int              gen_start;
    int              gen_step;
    bit [PROB_W-1:0] gen_prob;
    int              gen_lower;
    int              gen_upper;

    // predictor copy of the generator state
    longint    walk_value;
    longint    walk_step;
    bit        walk_started;
    bit [47:0] lcg_state;

    // handshake bookkeeping shared between the clocked processes
    bit          in_fire;
    bit          calm;
    bit          hold_req;
    int          hold_left;
    int          tx_gap;
    int          rx_gap;
    int unsigned cycles;
    int          mismatches;

    workload_value_generator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_interval     (s_interval),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_config_error (m_config_error),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // 48-bit drand48 step, low 48 bits of a 64-bit product are exact
    function automatic bit [47:0] lcg_advance();
        bit [63:0] prod;
        prod = {16'h0, lcg_state} * MULT_48 + INC_48;
        lcg_state = prod[47:0];
        return lcg_state;
    endfunction

    // the most negative step turns into the most positive one
    function automatic longint negate_step(longint s);
        return (s <= VALUE_MIN) ? VALUE_MAX : -s;
    endfunction

    // |step| * interval in Q8.8, truncated toward zero, sign put back
    function automatic longint scale_step(longint s, bit [INTERVAL_W-1:0] iv);
        longint unsigned mag;
        longint unsigned prod;
        mag = (s < 0) ? $unsigned(-s) : $unsigned(s);
        if ((mag >> 47) != 0)
            prod = STEP_CAP;
        else
            prod = (mag * iv) >> INTERVAL_FRAC;
        if (prod > STEP_CAP)
            prod = STEP_CAP;
        return (s < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic void reset_generator();
        gen_mode     = MODE_CONST;
        gen_start    = 0;
        gen_step     = 0;
        gen_prob     = PROB_HALF;
        gen_lower    = 0;
        gen_upper    = 0;
        walk_value   = 0;
        walk_step    = 0;
        walk_started = 1'b0;
        lcg_state    = SEED_48;
    endfunction

    // indexes past the last register are dropped and keep the walk going
    function automatic void apply_write(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] d);
        if (idx <= REG_UPPER) begin
            case (idx)
                REG_MODE:  gen_mode  = d[MODE_W-1:0];
                REG_START: gen_start = d;
                REG_STEP:  gen_step  = d;
                REG_PROB:  gen_prob  = d[PROB_W-1:0];
                REG_LOWER: gen_lower = d;
                default:   gen_upper = d;
            endcase
            walk_started = 1'b0;
        end
    endfunction

    // value produced by one tick, advancing the state
    function automatic gen_result_t next_value(bit [INTERVAL_W-1:0] iv);
        gen_result_t     res;
        longint          lo;
        longint          hi;
        longint          nv;
        longint          s;
        longint          base;
        longint unsigned span;
        longint unsigned offset;
        bit [PROB_W-1:0] keep;
        bit [47:0]       draw;
        lo = gen_lower;
        hi = gen_upper;
        keep = (gen_prob > PROB_ONE) ? PROB_ONE : gen_prob;
        res.value = '0;
        res.config_error = 1'b0;
        if (gen_mode == MODE_CONST) begin
            // bounds do not matter here
            res.value = gen_start;
        end else if (gen_mode > MODE_DWALK) begin
            // unused codes give zero and touch nothing
        end else if (lo > hi) begin
            // reversed bounds: flag only, state frozen
            res.config_error = 1'b1;
        end else if (gen_mode == MODE_UNIFORM) begin
            draw = lcg_advance();
            span = $unsigned(hi - lo);
            offset = (span * draw[47:16]) >> 32;
            nv = lo + $signed(offset);
            res.value = nv[VALUE_W-1:0];
        end else if (gen_mode == MODE_LINEAR) begin
            nv = walk_started ? walk_value + gen_step : gen_start;
            // below wraps to the top first, then above wraps to the bottom
            if (nv < lo)
                nv = hi;
            if (nv > hi)
                nv = lo;
            walk_value = nv;
            walk_started = 1'b1;
            res.value = nv[VALUE_W-1:0];
        end else begin
            base = walk_started ? walk_value : gen_start;
            s = (gen_mode == MODE_DWALK && walk_started) ? walk_step : gen_step;
            draw = lcg_advance();
            if ({16'h0, draw} > ({47'h0, keep} << 32))
                s = negate_step(s);
            nv = base + scale_step(s, iv);
            // clamp; the direction walk bounces off the bound it hit
            if (nv < lo) begin
                nv = lo;
                if (gen_mode == MODE_DWALK)
                    s = negate_step(s);
            end
            if (nv > hi) begin
                nv = hi;
                if (gen_mode == MODE_DWALK)
                    s = negate_step(s);
            end
            if (gen_mode == MODE_DWALK)
                walk_step = s;
            walk_value = nv;
            walk_started = 1'b1;
            res.value = nv[VALUE_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // q16.16 value: extremes, any 32 bits, or a spread around zero
    function automatic int pick_q16(int spread);
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom();
            default: return int'($urandom_range(0, 2 * spread)) - spread;
        endcase
    endfunction

    function automatic bit [INTERVAL_W-1:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return INTERVAL_W'($urandom_range(0, 16'h0200));
            default: return INTERVAL_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sequencing tasks, all run from the stimulus process
    // ------------------------------------------------------------------

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // whole register set; ends on a rising edge so later updates stay off the
    // falling edge where the driver and receiver run
    task automatic set_regs(bit [MODE_W-1:0] mode, int start, int step,
                            bit [PROB_W-1:0] prob, int lower, int upper);
        write_reg(REG_MODE, CFG_DATA_W'(mode));
        write_reg(REG_START, start);
        write_reg(REG_STEP, step);
        write_reg(REG_PROB, CFG_DATA_W'(prob));
        write_reg(REG_LOWER, lower);
        write_reg(REG_UPPER, upper);
        @(posedge aclk);
    endtask

    // all requests taken, every result back, then the pipeline's worth of quiet
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (pending_ticks.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_ticks(int n, bit [INTERVAL_W-1:0] iv);
        repeat (n) pending_ticks.push_back(iv);
        wait_idle();
    endtask

    task automatic random_phase(int n, bit long_hold);
        bit [MODE_W-1:0] mode;
        bit [PROB_W-1:0] prob;
        int              lo;
        int              hi;
        int              t;
        int              r;
        int              first;
        calm = long_hold || ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 19);
        if (r < 2)
            mode = MODE_CONST;
        else if (r < 6)
            mode = MODE_UNIFORM;
        else if (r < 10)
            mode = MODE_LINEAR;
        else if (r < 14)
            mode = MODE_RWALK;
        else if (r < 18)
            mode = MODE_DWALK;
        else
            mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        // bounds: now and then reversed or the full range, else ordered
        r = $urandom_range(0, 9);
        if (r == 0) begin
            lo = $urandom_range(1, 1 << 20);
            hi = -int'($urandom_range(0, 1 << 20));
        end else if (r == 1) begin
            lo = 32'h8000_0000;
            hi = 32'h7FFF_FFFF;
        end else begin
            lo = pick_q16(1 << 20);
            hi = pick_q16(1 << 20);
            if (lo > hi) begin
                t = lo;
                lo = hi;
                hi = t;
            end
        end
        case ($urandom_range(0, 5))
            0:       prob = '0;
            1:       prob = PROB_ONE;
            2:       prob = PROB_W'($urandom_range(PROB_ONE + 1, 17'h1FFFF));
            default: prob = PROB_W'($urandom_range(0, PROB_ONE));
        endcase
        set_regs(mode, pick_q16(1 << 20), pick_q16(1 << 18), prob, lo, hi);
        // receiver shuts off while the sender keeps offering
        if (long_hold)
            hold_req = 1'b1;
        first = n;
        if (!long_hold && n >= 8 && $urandom_range(0, 2) == 0)
            first = n / 2;
        repeat (first) pending_ticks.push_back(pick_interval());
        if (first != n) begin
            // sender pauses until the block has drained
            wait_idle();
            // a write past the last register must not restart the walk
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_SPARE, $urandom());
                @(posedge aclk);
            end
            repeat (n - first) pending_ticks.push_back(pick_interval());
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        int sent;
        int n;
        int phase;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register values straight out of reset
        run_ticks(1, 16'h0080);

        // constant mode at both extremes, interval extremes
        set_regs(MODE_CONST, 32'h7FFF_FFFF, 0, PROB_HALF, 0, 0);
        run_ticks(1, 16'hFFFF);
        run_ticks(1, 16'h0000);
        set_regs(MODE_CONST, 32'h8000_0000, 0, PROB_HALF, 0, 0);
        run_ticks(1, 16'h5555);

        // uniform over the full range, then with reversed bounds
        set_regs(MODE_UNIFORM, 0, 0, PROB_HALF, 32'h8000_0000, 32'h7FFF_FFFF);
        run_ticks(2, 16'hAAAA);
        set_regs(MODE_UNIFORM, 0, 0, PROB_HALF, 1, 0);
        run_ticks(1, 16'h0100);

        // constant mode must not care about reversed bounds
        set_regs(MODE_CONST, 12 * Q_ONE, 0, PROB_HALF, 1, 0);
        run_ticks(1, 16'h0100);

        // unused mode codes
        set_regs(MODE_UNUSED_FIRST, 5 * Q_ONE, Q_ONE, PROB_HALF, 0, 100 * Q_ONE);
        run_ticks(1, 16'h0100);
        set_regs(MODE_UNUSED_LAST, 5 * Q_ONE, Q_ONE, PROB_HALF, 0, 100 * Q_ONE);
        run_ticks(1, 16'h0100);

        // linear: wrap past the top, past the bottom, start outside the range
        set_regs(MODE_LINEAR, 90 * Q_ONE, 60 * Q_ONE, PROB_HALF, -100 * Q_ONE, 100 * Q_ONE);
        run_ticks(3, 16'h0100);
        set_regs(MODE_LINEAR, -90 * Q_ONE, -150 * Q_ONE, PROB_HALF,
                 -100 * Q_ONE, 100 * Q_ONE);
        run_ticks(2, 16'h0100);
        set_regs(MODE_LINEAR, 1000 * Q_ONE, 0, PROB_HALF, -100 * Q_ONE, 100 * Q_ONE);
        run_ticks(1, 16'h0100);

        // random walk: always flip the most negative step at full interval
        set_regs(MODE_RWALK, 0, 32'h8000_0000, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        run_ticks(2, 16'hFFFF);
        // probability above one acts as one
        set_regs(MODE_RWALK, 0, 3 * Q_ONE / 2, 17'h1FFFF, -100 * Q_ONE, 100 * Q_ONE);
        run_ticks(1, 16'h0100);
        run_ticks(1, 16'h0000);

        // direction walk runs into the top bound and turns round
        set_regs(MODE_DWALK, 0, 50 * Q_ONE, PROB_ONE, -100 * Q_ONE, 100 * Q_ONE);
        run_ticks(4, 16'h0100);

        // random phases, two of them with a long receiver hold-off
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            n = $urandom_range(10, 40);
            random_phase(n, phase == 1 || phase == 6);
            sent += n;
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[workload_value_generator] OK");
        else
            $display("[workload_value_generator] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // request driver: offers on the falling edge, holds until taken
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        bit offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offer = s_valid && !in_fire;
            if (!offer) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_ticks.size() != 0) begin
                    offer = 1'b1;
                    s_interval <= pending_ticks.pop_front();
                    tx_gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
                end
            end
            s_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stalls plus the long hold-off on request
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0)
                    rx_gap = gap_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: samples on the rising edge, predicts and checks
    // ------------------------------------------------------------------

    task automatic note_mismatch(string what, gen_result_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected value %0d error %0b, got value %0d error %0b",
                     $realtime, what, want.value, want.config_error,
                     m_value, m_config_error);
    endtask

    always @(posedge aclk) begin
        gen_result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[workload_value_generator] ERROR");
            $finish;
        end
        in_fire = s_valid && s_ready;
        if (!aresetn) begin
            reset_generator();
        end else begin
            if (cfg_we)
                apply_write(cfg_index, cfg_data);
            if (in_fire)
                expected_results.push_back(next_value(s_interval));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    want = '0;
                    note_mismatch("result with nothing outstanding", want);
                end else begin
                    want = expected_results.pop_front();
                    if (m_value !== want.value || m_config_error !== want.config_error)
                        note_mismatch("result mismatch", want);
                end
            end
        end
    end

endmodule
